[rtl/newton_reciprocal_inverse_sqrt_defines.svh]
// ----------------------------------------------------------------------------
// newton_reciprocal_inverse_sqrt_defines.svh
// Assertion macros used by the Newton reciprocal / inverse sqrt controller.
// ----------------------------------------------------------------------------
`ifndef NEWTON_RECIPROCAL_INVERSE_SQRT_DEFINES_SVH
`define NEWTON_RECIPROCAL_INVERSE_SQRT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NRIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nris assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NRIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nris assertion failed");

`endif

[rtl/nris_pkg.sv]
// ----------------------------------------------------------------------------
// nris_pkg
// Widths, fixed-point constants, codes and command type for the Newton unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nris_pkg;

  localparam int OPERAND_W          = 24;
  localparam int EST_W              = 32;
  localparam int INTER_W            = 33;
  localparam int PROD_W             = 2 * INTER_W;
  localparam int ITER_W             = 5;
  localparam int ESTIMATE_FRAC_BITS = 30;
  localparam int OPERAND_FRAC_BITS  = 16;
  localparam int DEF_MAX_STEPS      = 32;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(10);

  localparam logic signed [PROD_W-1:0] TWO_FIX   =
    signed'(PROD_W'(2)) <<< ESTIMATE_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] THREE_FIX =
    signed'(PROD_W'(3)) <<< ESTIMATE_FRAC_BITS;

  localparam logic MODE_RCP = 1'b0;
  localparam logic MODE_ISQ = 1'b1;

  localparam logic BSEL_R = 1'b0;
  localparam logic BSEL_Y = 1'b1;

  // reduction ops after a multiply
  localparam logic [2:0] RED_NONE = 3'd0;
  localparam logic [2:0] RED_T    = 3'd1;  // y = 2 - R*x
  localparam logic [2:0] RED_P    = 3'd2;  // y = R*x
  localparam logic [2:0] RED_Q    = 3'd3;  // y = 3 - p*x
  localparam logic [2:0] RED_XR   = 3'd4;  // x = x*y
  localparam logic [2:0] RED_XI   = 3'd5;  // x = x*y/2

  localparam logic [1:0] PH_LAST_RCP = 2'd1;
  localparam logic [1:0] PH_LAST_ISQ = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       b_sel;
    logic       red_en;
    logic [2:0] red_op;
    logic       out_load;
  } nris_cmd_t;

endpackage

`default_nettype wire

[rtl/nris_dp.sv]
// ----------------------------------------------------------------------------
// nris_dp
// Datapath: shared 33x33 multiplier, product register, shift/saturate logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nris_dp
  import nris_pkg::*;
(
  input  logic                    clk,
  input  nris_cmd_t               cmd,
  input  logic [OPERAND_W-1:0]    in_operand,
  input  logic signed [EST_W-1:0] in_initial_guess,
  output logic signed [EST_W-1:0] out_estimate,
  output logic                    out_saturated
);

  logic [OPERAND_W-1:0]     r_r;
  logic signed [EST_W-1:0]  x_r, x_nxt;
  logic signed [INTER_W-1:0] y_r, y_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [EST_W-1:0]  est_out_r;
  logic                     sat_out_r;

  logic signed [INTER_W-1:0] a_op, b_op;
  logic signed [PROD_W-1:0]  sh_frac, sh_est, sh_half;
  logic [INTER_W:0]          s1, s2;
  logic [EST_W:0]            se;

  function automatic logic [INTER_W:0] sat_inter(input logic signed [PROD_W-1:0] v);
    logic ovf;
    logic [INTER_W-1:0] val;
    ovf = (v[PROD_W-1:INTER_W-1] != {(PROD_W-INTER_W+1){v[INTER_W-1]}});
    if (!ovf) begin
      val = v[INTER_W-1:0];
    end else if (v[PROD_W-1]) begin
      val = {1'b1, {(INTER_W-1){1'b0}}};
    end else begin
      val = {1'b0, {(INTER_W-1){1'b1}}};
    end
    return {ovf, val};
  endfunction

  function automatic logic [EST_W:0] sat_est(input logic signed [PROD_W-1:0] v);
    logic ovf;
    logic [EST_W-1:0] val;
    ovf = (v[PROD_W-1:EST_W-1] != {(PROD_W-EST_W+1){v[EST_W-1]}});
    if (!ovf) begin
      val = v[EST_W-1:0];
    end else if (v[PROD_W-1]) begin
      val = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      val = {1'b0, {(EST_W-1){1'b1}}};
    end
    return {ovf, val};
  endfunction

  function automatic logic signed [PROD_W-1:0] sext_inter(input logic [INTER_W-1:0] v);
    return signed'({{(PROD_W-INTER_W){v[INTER_W-1]}}, v});
  endfunction

  always_comb begin
    a_op     = signed'({x_r[EST_W-1], x_r});
    b_op     = (cmd.b_sel == BSEL_R) ? signed'({{(INTER_W-OPERAND_W){1'b0}}, r_r}) : y_r;
    prod_nxt = a_op * b_op;

    sh_frac = prod_r >>> OPERAND_FRAC_BITS;
    sh_est  = prod_r >>> ESTIMATE_FRAC_BITS;
    sh_half = prod_r >>> (ESTIMATE_FRAC_BITS + 1);

    x_nxt   = x_r;
    y_nxt   = y_r;
    sat_nxt = sat_r;
    s1      = '0;
    s2      = '0;
    se      = '0;

    if (cmd.load) begin
      x_nxt   = in_initial_guess;
      sat_nxt = 1'b0;
    end else if (cmd.red_en) begin
      case (cmd.red_op)
        RED_T: begin
          s1      = sat_inter(sh_frac);
          s2      = sat_inter(TWO_FIX - sext_inter(s1[INTER_W-1:0]));
          y_nxt   = signed'(s2[INTER_W-1:0]);
          sat_nxt = sat_r | s1[INTER_W] | s2[INTER_W];
        end
        RED_P: begin
          s1      = sat_inter(sh_frac);
          y_nxt   = signed'(s1[INTER_W-1:0]);
          sat_nxt = sat_r | s1[INTER_W];
        end
        RED_Q: begin
          s1      = sat_inter(sh_est);
          s2      = sat_inter(THREE_FIX - sext_inter(s1[INTER_W-1:0]));
          y_nxt   = signed'(s2[INTER_W-1:0]);
          sat_nxt = sat_r | s1[INTER_W] | s2[INTER_W];
        end
        RED_XR: begin
          se      = sat_est(sh_est);
          x_nxt   = signed'(se[EST_W-1:0]);
          sat_nxt = sat_r | se[EST_W];
        end
        RED_XI: begin
          se      = sat_est(sh_half);
          x_nxt   = signed'(se[EST_W-1:0]);
          sat_nxt = sat_r | se[EST_W];
        end
        default: begin
          sat_nxt = sat_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_r <= in_operand;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    sat_r <= sat_nxt;
    if (cmd.out_load) begin
      est_out_r <= x_r;
      sat_out_r <= sat_r;
    end
  end

  assign out_estimate  = est_out_r;
  assign out_saturated = sat_out_r;

endmodule

`default_nettype wire

[rtl/nris_ctrl.sv]
// ----------------------------------------------------------------------------
// nris_ctrl
// Controller: step/phase sequencing, handshakes and the iteration register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "newton_reciprocal_inverse_sqrt_defines.svh"

module nris_ctrl
  import nris_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_wr_en,
  input  logic [ITER_W-1:0] cfg_wr_data,
  output nris_cmd_t         cmd
);

  localparam int SCNT_W = $clog2(MAX_STEPS + 1);
  localparam int CMP_W  = (SCNT_W > ITER_W + 1) ? SCNT_W : ITER_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [SCNT_W-1:0] rem_r, rem_nxt;
  logic              mode_r, mode_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CMP_W-1:0]  steps_full, steps_lim;
  logic [1:0]        last_phase;

  always_comb begin
    steps_full = CMP_W'(iter_r) + CMP_W'(1);
    steps_lim  = (steps_full > CMP_W'(MAX_STEPS)) ? CMP_W'(MAX_STEPS) : steps_full;
    last_phase = (mode_r == MODE_ISQ) ? PH_LAST_ISQ : PH_LAST_RCP;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    mode_nxt      = mode_r;
    iter_nxt      = cfg_wr_en ? cfg_wr_data : iter_r;
    out_valid_nxt = out_valid_r;

    cmd        = '0;
    cmd.b_sel  = (phase_r == 2'd0) ? BSEL_R : BSEL_Y;
    if (mode_r == MODE_RCP) begin
      cmd.red_op = (phase_r == 2'd0) ? RED_T : RED_XR;
    end else begin
      case (phase_r)
        2'd0:    cmd.red_op = RED_P;
        2'd1:    cmd.red_op = RED_Q;
        default: cmd.red_op = RED_XI;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          mode_nxt  = in_mode;
          phase_nxt = 2'd0;
          rem_nxt   = steps_lim[SCNT_W-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_RED;
      end
      S_RED: begin
        cmd.red_en = 1'b1;
        if (phase_r == last_phase) begin
          phase_nxt = 2'd0;
          if (rem_r == SCNT_W'(1)) begin
            state_nxt = S_OUT;
          end else begin
            rem_nxt   = rem_r - SCNT_W'(1);
            state_nxt = S_MUL;
          end
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 2'd0;
      rem_r       <= '0;
      mode_r      <= MODE_RCP;
      iter_r      <= ITER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
      mode_r      <= mode_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `NRIS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `NRIS_ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `NRIS_ASSERT_NEXT(a_mul_then_red, clk, rst_n, cmd.mul_en, cmd.red_en)
  `NRIS_ASSERT_SAME(a_rem_nonzero, clk, rst_n, state_r == S_MUL, rem_r != '0)

endmodule

`default_nettype wire

[rtl/newton_reciprocal_inverse_sqrt.sv]
// Newton-Raphson reciprocal / inverse square root unit. Each transaction
// carries a mode, an unsigned Q8.16 operand R and a signed Q2.30 starting
// guess; the unit runs iteration_count + 1 Newton steps (capped at MAX_STEPS)
// and returns the Q2.30 estimate plus a flag set if any intermediate or
// estimate clamped. One item is processed at a time through a single shared
// 33x33 multiplier; each multiply is registered and its shift/saturate done in
// a separate state, two multiplies per reciprocal step and three per inverse
// sqrt step. The unit goes back to idle as out_valid rises, and a result waits
// in an output register, so the next transaction is taken meanwhile; a result
// is held back while the previous one has not yet been taken.
// ----------------------------------------------------------------------------
// newton_reciprocal_inverse_sqrt
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module newton_reciprocal_inverse_sqrt
  import nris_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [OPERAND_W-1:0]    in_operand,
  input  logic signed [EST_W-1:0] in_initial_guess,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [EST_W-1:0] out_estimate,
  output logic                    out_saturated,
  input  logic                    cfg_wr_en,
  input  logic [ITER_W-1:0]       cfg_wr_data
);

  nris_cmd_t cmd;

  nris_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd)
  );

  nris_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .in_operand       (in_operand),
    .in_initial_guess (in_initial_guess),
    .out_estimate     (out_estimate),
    .out_saturated    (out_saturated)
  );

endmodule

`default_nettype wire

[test/tb_newton_reciprocal_inverse_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_newton_reciprocal_inverse_sqrt
// Self-checking bench for the Newton reciprocal / inverse sqrt unit. A local
// fixed-point predictor computes each expected estimate and clamp flag; a
// checker compares every result transaction against the oldest prediction.
// Directed tests come first, then mostly convergent random transactions
// with noise, under several iteration counts and idle/stall mixes.
// ----------------------------------------------------------------------------

module tb_newton_reciprocal_inverse_sqrt;
  import nris_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 185;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic                    saturated;
  } newton_result_t;

  logic                    clk;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_ready;
  logic                    in_mode          = MODE_RCP;
  logic [OPERAND_W-1:0]    in_operand       = '0;
  logic signed [EST_W-1:0] in_initial_guess = '0;
  logic                    out_valid;
  logic                    out_ready        = 1'b0;
  logic signed [EST_W-1:0] out_estimate;
  logic                    out_saturated;
  logic                    cfg_wr_en        = 1'b0;
  logic [ITER_W-1:0]       cfg_wr_data      = ITER_RESET;

  logic [ITER_W-1:0] iter_count_model = ITER_RESET;
  newton_result_t    expected_results[$];
  newton_result_t    head_result;
  int                send_idle_pct    = 0;
  int                recv_stall_pct   = 0;
  int                mismatches       = 0;
  int                results_seen     = 0;
  int                quiet_cycles     = 0;

  newton_reciprocal_inverse_sqrt dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_operand       (in_operand),
    .in_initial_guess (in_initial_guess),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_estimate     (out_estimate),
    .out_saturated    (out_saturated),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_to(input logic signed [127:0] v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return longint'(v);
  endfunction

  // floor(a*b / 2^s)
  function automatic logic signed [127:0] mul_floor_shift(input longint a, input longint b,
                                                          input int s);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = 128'(a);
    wb = 128'(b);
    return (wa * wb) >>> s;
  endfunction

  function automatic newton_result_t newton_predict(input logic mode,
                                                    input logic [OPERAND_W-1:0] r_in,
                                                    input logic signed [EST_W-1:0] g,
                                                    input logic [ITER_W-1:0] count);
    longint              r, x, one, p, q, u;
    logic signed [127:0] w;
    int                  steps, i;
    bit                  clamped;
    newton_result_t      res;
    r = longint'(r_in);
    x = longint'(g);
    one = longint'(1) <<< ESTIMATE_FRAC_BITS;
    steps = int'(count) + 1;
    if (steps > DEF_MAX_STEPS) steps = DEF_MAX_STEPS;
    clamped = 1'b0;
    for (i = 0; i < steps; i++) begin
      w = mul_floor_shift(r, x, OPERAND_FRAC_BITS);
      p = sat_to(w, INTER_W);
      if (p != w) clamped = 1'b1;
      if (mode == MODE_ISQ) begin
        w = mul_floor_shift(p, x, ESTIMATE_FRAC_BITS);
        q = sat_to(w, INTER_W);
        if (q != w) clamped = 1'b1;
        w = 128'(3 * one - q);
        u = sat_to(w, INTER_W);
        if (u != w) clamped = 1'b1;
        w = mul_floor_shift(x, u, ESTIMATE_FRAC_BITS + 1);
      end else begin
        w = 128'(2 * one - p);
        u = sat_to(w, INTER_W);
        if (u != w) clamped = 1'b1;
        w = mul_floor_shift(x, u, ESTIMATE_FRAC_BITS);
      end
      x = sat_to(w, EST_W);
      if (x != w) clamped = 1'b1;
    end
    res.estimate  = EST_W'(x);
    res.saturated = clamped;
    return res;
  endfunction

  // starting guess within a factor of 0.5..1.5 of the true root
  function automatic logic signed [EST_W-1:0] near_root_guess(input logic mode,
                                                              input logic [OPERAND_W-1:0] r_in);
    real    rv, root, g;
    longint gl;
    rv = real'(r_in) / 65536.0;
    root = (mode == MODE_ISQ) ? 1.0 / $sqrt(rv) : 1.0 / rv;
    g = root * (0.5 + $urandom_range(1000) / 1000.0);
    gl = longint'(g * 1073741824.0);
    if (gl > 64'sd2147483647) gl = 64'sd2147483647;
    return EST_W'(gl);
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: estimate %0d saturated %0b",
                     out_estimate, out_saturated);
        end else begin
          head_result = expected_results.pop_front();
          if (out_estimate !== head_result.estimate ||
              out_saturated !== head_result.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected estimate %0d sat %0b, got %0d sat %0b",
                       results_seen, head_result.estimate, head_result.saturated,
                       out_estimate, out_saturated);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_newton_reciprocal_inverse_sqrt: FAIL");
    $finish;
  end

  // ------------------------------------------------------------------ drivers
  task automatic send_item(input logic mode, input logic [OPERAND_W-1:0] operand,
                           input logic signed [EST_W-1:0] guess);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_operand       <= operand;
    in_initial_guess <= guess;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(newton_predict(mode, operand, guess, iter_count_model));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_iteration_count(input logic [ITER_W-1:0] count);
    wait_for_results();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    iter_count_model = count;
  endtask

  task automatic send_random_item();
    logic                    mode;
    logic [OPERAND_W-1:0]    operand;
    logic [OPERAND_W-1:0]    floor_r;
    logic signed [EST_W-1:0] guess;
    mode = 1'($urandom_range(1));
    if ($urandom_range(99) < 75) begin
      floor_r = (mode == MODE_ISQ) ? 24'h004001 : 24'h008001;
      if ($urandom_range(1))
        operand = OPERAND_W'($urandom_range(floor_r * 8, floor_r));
      else
        operand = OPERAND_W'($urandom_range(24'hFFFFFF, floor_r));
      guess = near_root_guess(mode, operand);
    end else begin
      operand = OPERAND_W'($urandom);
      guess   = EST_W'($urandom);
      case ($urandom_range(3))
        0: operand = '0;
        1: guess = (operand == 0) ? guess : -near_root_guess(mode, operand);
        default: ;
      endcase
    end
    send_item(mode, operand, guess);
  endtask

  task automatic run_random_items(input int n, input int idle_pct, input int stall_pct,
                                  input logic [ITER_W-1:0] count, input bit pause_midway);
    int i;
    set_iteration_count(count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) wait_for_results();
      send_random_item();
    end
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_reset_count();
    send_item(MODE_RCP, 24'h020000, 32'sh1999_9999);
    send_item(MODE_ISQ, 24'h040000, 32'sh1999_9999);
    send_item(MODE_RCP, 24'h030000, 32'sh1333_3333);
  endtask

  task automatic test_field_extremes();
    logic [OPERAND_W-1:0]    ops[3];
    logic signed [EST_W-1:0] guesses[3];
    int m, o, g;
    ops     = '{24'h000000, 24'h000001, 24'hFFFFFF};
    guesses = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000};
    set_iteration_count(5'd0);
    for (m = 0; m < 2; m++)
      for (o = 0; o < 3; o++)
        for (g = 0; g < 3; g++)
          send_item(m[0], ops[o], guesses[g]);
  endtask

  task automatic test_long_iterations();
    set_iteration_count(5'd31);
    send_item(MODE_RCP, 24'h018000, 32'sh2000_0000);
    send_item(MODE_ISQ, 24'h008000, 32'sh4000_0000);
    send_item(MODE_RCP, 24'h050000, -32'sh0400_0000);
    send_item(MODE_ISQ, 24'hFFFFFF, 32'sh0010_0000);
  endtask

  task automatic test_no_idle();
    run_random_items(PHASE_ITEMS, 0, 0, ITER_W'($urandom_range(31)), 1'b0);
  endtask

  task automatic test_sender_idle();
    run_random_items(PHASE_ITEMS, 82, 0, 5'd0, 1'b0);
  endtask

  task automatic test_receiver_stall();
    run_random_items(PHASE_ITEMS, 0, 82, 5'd31, 1'b0);
  endtask

  task automatic test_both_idle();
    run_random_items(PHASE_ITEMS, 27, 27, ITER_W'($urandom_range(31)), 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_count();
    test_field_extremes();
    test_long_iterations();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    wait_for_results();
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_newton_reciprocal_inverse_sqrt: PASS");
    else
      $display("tb_newton_reciprocal_inverse_sqrt: FAIL");
    $finish;
  end

endmodule
